@@ design/tcwm_pkg.sv @@
package tcwm_pkg;

  // word widths
  localparam int CODE_W = 16;
  localparam int DEG_W  = 9;
  localparam int MEAN_W = 8;

  // default averaging window depth
  localparam int DEFAULT_WINDOW = 8;

  // degrees = (SCALE_NUM * code - OFFSET_NUM) / (2^FRAC_SHIFT * 100)
  localparam logic [14:0] SCALE_NUM  = 15'd17572;
  localparam logic [31:0] OFFSET_NUM = 32'd307036160;
  localparam int          FRAC_SHIFT = 16;

  // divide by 100 as multiply by reciprocal, exact for numerators below 43690
  localparam int          MAG_W         = 14;
  localparam logic [12:0] DIV100_RECIP  = 13'd5243;
  localparam int          DIV100_SHIFT  = 19;
  localparam int          DIV100_PROD_W = 27;

endpackage

@@ design/temperature_code_window_mean.sv @@
// Temperature code window mean.
// Input channel: in_valid / in_ready carry one 16-bit raw sensor code per word.
// Output channel: out_valid / out_ready carry the code converted to whole
// degrees (signed, truncated toward zero) and the low byte of the truncated
// mean of the last WINDOW converted values.
// The pipeline takes one word per cycle while in_ready is high. Stages:
// input register, code scaling multiply, offset and magnitude,
// divide-by-100 reciprocal multiply, window update (ring memory with one
// pre-read slot and running sum), mean magnitude, and the divide-by-WINDOW
// reciprocal multiply into the output register.
// The window update stage is the only loop: the running sum closes on itself
// through one subtract and one add.
// Reset clears the pipeline valids, the write pointer, the running sum and the
// per-entry fill bits; unwritten entries read as zero and count in the mean.
// When the receiver stalls, words collect in the pipeline stages; in_ready
// drops only once every stage holds a word.
module temperature_code_window_mean #(
  parameter int WINDOW = tcwm_pkg::DEFAULT_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tcwm_pkg::CODE_W-1:0]       in_raw_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tcwm_pkg::DEG_W-1:0] out_degrees,
  output logic [tcwm_pkg::MEAN_W-1:0]       out_mean_low_byte
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int PTR_W  = (WINDOW > 1) ? LOG_W : 1;
  localparam int SUM_W  = tcwm_pkg::DEG_W + 1 + LOG_W;
  localparam int ABS_W  = SUM_W - 1;
  localparam int RSH    = ABS_W + LOG_W + 1;
  localparam int PROD_W = ABS_W + RSH + 1;
  localparam logic [RSH:0] WIN_RECIP =
    (RSH + 1)'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int NUM_W  = 32;

  // stage valids and flow control
  logic [6:0] vld_r;
  logic [6:0] free;

  always_comb begin
    free[6] = !vld_r[6] || out_ready;
    for (int k = 5; k >= 0; k--) begin
      free[k] = !vld_r[k] || free[k+1];
    end
  end

  assign in_ready = free[0];
  assign out_valid = vld_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (free[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < 7; k++) begin
        if (free[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: input register
  logic [tcwm_pkg::CODE_W-1:0] code1_r;
  always_ff @(posedge clk) begin
    if (free[0] && in_valid) code1_r <= in_raw_code;
  end

  // stage 2: scale multiply
  logic [30:0] prod2_r;
  always_ff @(posedge clk) begin
    if (free[1] && vld_r[0]) prod2_r <= 31'(code1_r) * 31'(tcwm_pkg::SCALE_NUM);
  end

  // stage 3: remove offset, split into sign and magnitude, drop fraction bits
  logic signed [NUM_W-1:0] num3;
  logic [NUM_W-1:0]        abs3;
  logic [tcwm_pkg::MAG_W-1:0] mag3_r;
  logic                       neg3_r;

  always_comb begin
    num3 = $signed({1'b0, prod2_r}) - $signed(tcwm_pkg::OFFSET_NUM);
    abs3 = num3[NUM_W-1] ? NUM_W'(-num3) : NUM_W'(num3);
  end

  always_ff @(posedge clk) begin
    if (free[2] && vld_r[1]) begin
      mag3_r <= abs3[tcwm_pkg::FRAC_SHIFT +: tcwm_pkg::MAG_W];
      neg3_r <= num3[NUM_W-1];
    end
  end

  // stage 4: magnitude / 100 by reciprocal multiply
  logic [tcwm_pkg::DIV100_PROD_W-1:0] p4;
  logic [7:0]                         q4_r;
  logic                               neg4_r;

  assign p4 = tcwm_pkg::DIV100_PROD_W'(mag3_r)
            * tcwm_pkg::DIV100_PROD_W'(tcwm_pkg::DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (free[3] && vld_r[2]) begin
      q4_r   <= p4[tcwm_pkg::DIV100_SHIFT +: 8];
      neg4_r <= neg3_r;
    end
  end

  // stage 5: window update
  logic signed [tcwm_pkg::DEG_W-1:0] deg5;
  logic signed [tcwm_pkg::DEG_W-1:0] old_val;
  logic signed [tcwm_pkg::DEG_W-1:0] old_r;
  logic                              old_vld_r;
  logic signed [tcwm_pkg::DEG_W-1:0] deg5_r;
  logic signed [SUM_W-1:0]           sum_r;
  logic signed [SUM_W-1:0]           sum_nxt;
  logic [PTR_W-1:0]                  ptr_r;
  logic [PTR_W-1:0]                  ptr_nxt;
  logic [WINDOW-1:0]                 filled_r;
  logic                              win_en;
  logic signed [tcwm_pkg::DEG_W-1:0] store_mem [WINDOW];

  always_comb begin
    deg5    = neg4_r ? -$signed({1'b0, q4_r}) : $signed({1'b0, q4_r});
    old_val = old_vld_r ? old_r : '0;
    sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(deg5);
    ptr_nxt = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
    win_en  = free[4] && vld_r[3];
  end

  // control state: pointer, sum, fill bits, pre-read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      sum_r     <= '0;
      filled_r  <= '0;
      old_vld_r <= 1'b0;
    end else if (win_en) begin
      ptr_r           <= ptr_nxt;
      sum_r           <= sum_nxt;
      filled_r[ptr_r] <= 1'b1;
      old_vld_r       <= (WINDOW == 1) ? 1'b1 : filled_r[ptr_nxt];
    end
  end

  // ring memory: write current slot, pre-read the next one
  always_ff @(posedge clk) begin
    if (win_en) begin
      store_mem[ptr_r] <= deg5;
      old_r            <= (WINDOW == 1) ? deg5 : store_mem[ptr_nxt];
      deg5_r           <= deg5;
    end
  end

  // stage 6: mean sign and magnitude (sum_r belongs to the word in stage 5)
  logic [ABS_W-1:0]                  abs6_r;
  logic                              neg6_r;
  logic signed [tcwm_pkg::DEG_W-1:0] deg6_r;
  logic [SUM_W-1:0]                  sum_abs;

  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (free[5] && vld_r[4]) begin
      abs6_r <= sum_abs[ABS_W-1:0];
      neg6_r <= sum_r[SUM_W-1];
      deg6_r <= deg5_r;
    end
  end

  // stage 7: divide by WINDOW via reciprocal, restore sign, output register
  logic [PROD_W-1:0]               p7;
  logic [tcwm_pkg::MEAN_W-1:0]     qm7;
  logic [tcwm_pkg::MEAN_W-1:0]     mean_r;
  logic signed [tcwm_pkg::DEG_W-1:0] degrees_r;

  always_comb begin
    p7  = PROD_W'(abs6_r) * PROD_W'(WIN_RECIP);
    qm7 = p7[RSH +: tcwm_pkg::MEAN_W];
  end

  always_ff @(posedge clk) begin
    if (free[6] && vld_r[5]) begin
      mean_r    <= neg6_r ? (~qm7 + 1'b1) : qm7;
      degrees_r <= deg6_r;
    end
  end

  assign out_degrees       = degrees_r;
  assign out_mean_low_byte = mean_r;

  // converted value always lies in the sensor's range
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_degrees) >= -46 && int'(out_degrees) <= 128))
    else $error("degrees out of range");

  // running sum stays within WINDOW times the value range
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(sum_r) >= -46 * WINDOW && int'(sum_r) <= 128 * WINDOW))
    else $error("window sum out of range");

  // write pointer never leaves the window
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ptr_r) < WINDOW)
    else $error("write pointer beyond window");

  // after reset the pipeline is empty and takes input
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ sim/tb_temperature_code_window_mean.sv @@
module tb_temperature_code_window_mean;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = tcwm_pkg::DEFAULT_WINDOW;

  // exact rational form of the code-to-degrees conversion
  localparam longint CODE_SCALE  = 17572;
  localparam longint CODE_OFFSET = 307036160;
  localparam longint CODE_DIV    = 6553600;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL  = 150;   // last words driven with no idling
  localparam int DRAIN_WAIT  = 20;    // pipeline is 7 deep

  typedef struct packed {
    logic signed [tcwm_pkg::DEG_W-1:0] degrees;
    logic [tcwm_pkg::MEAN_W-1:0]       mean_low_byte;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [tcwm_pkg::CODE_W-1:0] in_raw_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tcwm_pkg::DEG_W-1:0] out_degrees;
  logic [tcwm_pkg::MEAN_W-1:0] out_mean_low_byte;

  logic [tcwm_pkg::CODE_W-1:0] pending_codes[$];
  reading_t                    expected_readings[$];

  // predictor state: window ring, write slot and running sum
  int window_deg[WIN];
  int window_slot;
  int window_total;

  int errors;
  int readings_checked;
  int codes_sent;
  int cycle_count;
  bit quiet;
  int send_gap;
  int recv_stall;

  temperature_code_window_mean #(.WINDOW(WIN)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_code      (in_raw_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_degrees      (out_degrees),
    .out_mean_low_byte(out_mean_low_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // convert one code, update the window and return the expected reading
  task automatic window_update(input logic [tcwm_pkg::CODE_W-1:0] code,
                               output reading_t rd);
    longint num;
    int deg;
    int avg;
    num = longint'(code) * CODE_SCALE - CODE_OFFSET;
    deg = int'(num / CODE_DIV);
    window_total = window_total - window_deg[window_slot] + deg;
    window_deg[window_slot] = deg;
    window_slot = (window_slot + 1) % WIN;
    avg = window_total / WIN;
    rd.degrees = deg[tcwm_pkg::DEG_W-1:0];
    rd.mean_low_byte = avg[tcwm_pkg::MEAN_W-1:0];
  endtask

  // input driver: takes the next word from the pending queue
  always @(posedge clk) begin
    reading_t rd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        window_update(in_raw_code, rd);
        expected_readings.push_back(rd);
        codes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_codes.size() <= QUIET_TAIL) quiet = 1'b1;
        if (send_gap > 0 && !quiet) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_codes.size() > 0) begin
          in_valid <= 1'b1;
          in_raw_code <= pending_codes.pop_front();
          // occasionally schedule an idle burst after this word
          if ($urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each word against the oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected output word degrees=%0d mean=0x%02h",
                     out_degrees, out_mean_low_byte);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (out_degrees !== want.degrees ||
              out_mean_low_byte !== want.mean_low_byte) begin
            if (errors < 10)
              $display("ERROR: word %0d: degrees exp %0d got %0d, mean exp 0x%02h got 0x%02h",
                       readings_checked, want.degrees, out_degrees,
                       want.mean_low_byte, out_mean_low_byte);
            errors++;
          end
        end
      end
      // receiver backpressure in random bursts
      if (recv_stall > 0 && !quiet) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 11) == 0) recv_stall = $urandom_range(1, 19);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings still outstanding",
               cycle_count, expected_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    foreach (window_deg[i]) window_deg[i] = 0;
    window_slot = 0;
    window_total = 0;

    // directed: range ends, both sides of the zero crossing, bit patterns
    pending_codes = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'd17100, 16'd17101,
                      16'd17472, 16'd17473, 16'h8000, 16'h5555, 16'hAAAA,
                      16'h00FF, 16'hFF00};
    // full window of the coldest value: negative mean wraps in the low byte
    repeat (WIN) pending_codes.push_back(16'd0);
    // climb back toward the hottest value, mixed-sign sums on the way
    repeat (4) pending_codes.push_back(16'hFFFF);

    // random codes, biased toward the cold end and the extremes
    repeat (1800) begin
      pick = $urandom_range(0, 19);
      if (pick < 13)
        pending_codes.push_back(tcwm_pkg::CODE_W'($urandom_range(0, 65535)));
      else if (pick < 16)
        pending_codes.push_back(tcwm_pkg::CODE_W'($urandom_range(0, 17472)));
      else if (pick < 18)
        pending_codes.push_back(tcwm_pkg::CODE_W'($urandom_range(0, 15)));
      else
        pending_codes.push_back(tcwm_pkg::CODE_W'($urandom_range(65520, 65535)));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_codes.size() > 0 || in_valid) @(posedge clk);
    while (expected_readings.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d temperature codes through a %0d-deep averaging window",
             codes_sent, WIN);
    $display("Checked %0d readings, %0d mismatches, with random stalls on both sides",
             readings_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
